// ----- rtl/core/modexp_pkg.sv -----
`default_nettype none
package modexp_pkg;
   localparam int WORD_BITS = 64;
   localparam int BIT_CNT_W = $clog2(WORD_BITS);

   typedef logic [WORD_BITS-1:0] word_type;

   localparam logic [0:0] CSR_MODULUS    = 1'b0;
   localparam logic [0:0] CSR_RECIPROCAL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MUL,
      ST_SQR,
      ST_DONE
   } state_type;

   // request to the shared modular multiplier
   typedef struct packed {
      logic     start;
      word_type x;
      word_type y;
   } mul_req_type;

   typedef struct packed {
      logic     done;
      word_type product;
   } mul_rsp_type;
endpackage
`default_nettype wire

// ----- rtl/core/modular_exponentiation.sv -----
`default_nettype none
// modular exponentiation: rsp residue = base_value ^ power mod modulus
//
// channels: req (base and exponent in), rsp (residue out), csr (register writes)
// csr index 0 is the modulus, index 1 the reciprocal (kept, not used by the math)
// write csr only while the block is idle
//
// one word is taken at a time; req_tready is low while a word is in work
// the base is first reduced mod modulus, then each exponent bit gets a check
// step, every bit below the top set one a square on the shared bit-serial
// multiplier and every set bit a multiply on it; special cases (modulus zero
// or one, zero base, zero exponent) still take the base reduction pass
//
// reset (synchronous, active high) sets modulus to 1, reciprocal to 0 and
// drops all work; a stalled rsp holds its word until taken, and no new req
// is taken until then
module modular_exponentiation (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [127:0] req_tdata,   // base_value[63:0], power[127:64]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,    // residue[63:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import modexp_pkg::*;

   state_type   state_ff, state_in;
   word_type    modulus_ff, recip_ff;
   word_type    base_ff, base_in;     // running square
   word_type    exp_ff, exp_in;
   word_type    acc_ff, acc_in;       // running product
   logic        zero_ff, zero_in;     // result forced to zero
   logic        red_start;
   logic        red_done;
   word_type    red_rem;
   mul_req_type mreq;
   mul_rsp_type mrsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= word_type'(1);
         recip_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MODULUS:    modulus_ff <= csr_data[WORD_BITS-1:0];
            CSR_RECIPROCAL: recip_ff   <= csr_data[WORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   modexp_reduce u_reduce (
      .clock    (clock),
      .reset    (reset),
      .start    (red_start),
      .value    (req_tdata[WORD_BITS-1:0]),
      .modulus  (modulus_ff),
      .done     (red_done),
      .remainder(red_rem)
   );

   modexp_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .modulus(modulus_ff),
      .req    (mreq),
      .rsp    (mrsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_REDUCE;
         ST_REDUCE: if (red_done) state_in = ST_CHECK;
         ST_CHECK: begin
            if (zero_ff || exp_ff == '0) state_in = ST_DONE;
            else if (exp_ff[0])          state_in = ST_MUL;
            else                         state_in = ST_SQR;
         end
         ST_MUL: begin
            if (mrsp.done) state_in = (exp_ff[WORD_BITS-1:1] == '0) ? ST_DONE : ST_SQR;
         end
         ST_SQR:    if (mrsp.done) state_in = ST_CHECK;
         ST_DONE:   if (rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and unit control
   always_comb begin
      base_in   = base_ff;
      exp_in    = exp_ff;
      acc_in    = acc_ff;
      zero_in   = zero_ff;
      red_start = 1'b0;
      mreq      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               red_start = 1'b1;
               exp_in    = req_tdata[64 +: WORD_BITS];
               zero_in   = (modulus_ff <= word_type'(1))
                        || (req_tdata[WORD_BITS-1:0] == '0 && req_tdata[64 +: WORD_BITS] != '0);
               acc_in    = word_type'(1);
            end
         end
         ST_REDUCE: if (red_done) base_in = red_rem;
         ST_CHECK: begin
            if (!(zero_ff || exp_ff == '0)) begin
               mreq.start = 1'b1;
               mreq.x     = exp_ff[0] ? acc_ff : base_ff;
               mreq.y     = base_ff;
            end
         end
         ST_MUL: begin
            if (mrsp.done) begin
               acc_in = mrsp.product;
               if (exp_ff[WORD_BITS-1:1] != '0) begin
                  mreq.start = 1'b1;
                  mreq.x     = base_ff;
                  mreq.y     = base_ff;
               end
            end
         end
         ST_SQR: begin
            if (mrsp.done) begin
               base_in = mrsp.product;
               exp_in  = exp_ff >> 1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      exp_ff  <= exp_in;
      acc_ff  <= acc_in;
      zero_ff <= zero_in;
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_DONE);
   assign rsp_tdata  = zero_ff ? 64'd0 : acc_ff;
endmodule
`default_nettype wire

// ----- rtl/core/modexp_mulmod.sv -----
`default_nettype none
// bit-serial (x*y) mod n, one double-and-add step per cycle, msb of y first
module modexp_mulmod (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire modexp_pkg::word_type  modulus,
   input  wire modexp_pkg::mul_req_type req,
   output modexp_pkg::mul_rsp_type    rsp
);
   import modexp_pkg::*;

   word_type             acc_ff, acc_in;
   word_type             x_ff, x_in;
   word_type             y_ff, y_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   word_type             dbl;
   word_type             room;

   always_comb begin
      // acc + acc mod n
      room = modulus - acc_ff;
      dbl  = (acc_ff >= room) ? acc_ff - room : acc_ff + acc_ff;
   end

   always_comb begin
      word_type r2;
      r2      = modulus - x_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         acc_in  = '0;
         x_in    = req.x;
         y_in    = req.y;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff[WORD_BITS-1])
            acc_in = (dbl >= r2) ? dbl - r2 : dbl + x_ff;
         else
            acc_in = dbl;
         y_in   = {y_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == BIT_CNT_W'(WORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;
endmodule
`default_nettype wire

// ----- rtl/core/modexp_reduce.sv -----
`default_nettype none
// a mod n by restoring shift-subtract, one quotient bit per cycle
module modexp_reduce (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire modexp_pkg::word_type value,
   input  wire modexp_pkg::word_type modulus,
   output logic                      done,
   output modexp_pkg::word_type      remainder
);
   import modexp_pkg::*;

   word_type             rem_ff, rem_in;
   word_type             num_ff, num_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   always_comb begin
      logic [WORD_BITS:0] sh;
      sh      = {rem_ff, num_ff[WORD_BITS-1]};
      rem_in  = rem_ff;
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         num_in  = value;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, modulus})
            rem_in = WORD_BITS'(sh - {1'b0, modulus});
         else
            rem_in = sh[WORD_BITS-1:0];
         num_in = {num_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == BIT_CNT_W'(WORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ----- rtl/core/modexp_checker.sv -----
`default_nettype none
module modexp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);
   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed under stall");

   // never ready for a request while a result is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("req ready while rsp pending");

   // an accepted request is followed by a busy block: not ready, no result
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !rsp_tvalid)
      else $error("block not busy after request");

   // after reset nothing is pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");
endmodule

bind modular_exponentiation modexp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
`default_nettype wire
